// ----- rtl/top_k_inner_product_search_macros.svh -----
// assertion macros for the top-k inner product search block
`ifndef TOP_K_INNER_PRODUCT_SEARCH_MACROS_SVH
`define TOP_K_INNER_PRODUCT_SEARCH_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define TKIPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define TKIPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tkips_pkg.sv -----
// types and constants for the top-k inner product search block
package tkips_pkg;

    localparam int ELEMENT_BITS = 16;
    localparam int ID_BITS      = 32;
    localparam int SCORE_BITS   = 48;
    localparam int PROD_BITS    = 2 * ELEMENT_BITS;
    localparam int TOPK_BITS    = 5;
    localparam logic [TOPK_BITS-1:0] TOPK_RESET = 5'd10;

    localparam logic [1:0] ACT_QUERY = 2'd0;
    localparam logic [1:0] ACT_CAND  = 2'd1;
    localparam logic [1:0] ACT_DRAIN = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [1:0] KIND_SCORED  = 2'd0;
    localparam logic [1:0] KIND_DROPPED = 2'd1;
    localparam logic [1:0] KIND_RANKED  = 2'd2;
    localparam logic [1:0] KIND_EMPTY   = 2'd3;

    localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

    typedef struct packed {
        logic [1:0]                     action;
        logic signed [ELEMENT_BITS-1:0] element_value;
        logic [ID_BITS-1:0]             candidate_id;
        logic                           last_element;
    } t_in_word;

    typedef struct packed {
        logic [1:0]                   kind;
        logic [ID_BITS-1:0]           entry_id;
        logic signed [SCORE_BITS-1:0] entry_score;
        logic                         last_in_run;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_RES,
        S_EVICT,
        S_PUT,
        S_DRAIN
    } t_state;

endpackage

// ----- rtl/top_k_inner_product_search.sv -----
// top-k inner product search: query store, shared multiply-accumulate, sorted best store
// query element: stored in ram; candidate element: ram read, mul, acc if it multiplies
// candidate end: result word when output frees; if scored, sorted insert (evict, put)
// drain: one ranked word per cycle as output frees, n for n kept entries, one empty if none
// reset (synchronous, active low) empties query, counter, accumulator and store; top_k is 10
module top_k_inner_product_search #(
    parameter int MAX_DIM  = 1024,
    parameter int MAX_KEEP = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tkips_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tkips_pkg::t_out_word o_out_word,
    input  logic                 i_cfg_we,
    input  logic [tkips_pkg::TOPK_BITS-1:0] i_cfg_data
);
    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int FW = $clog2(MAX_KEEP + 1);
    localparam int KW = 8;
    localparam int EB = tkips_pkg::ELEMENT_BITS;
    localparam int SB = tkips_pkg::SCORE_BITS;
    localparam int PB = tkips_pkg::PROD_BITS;
    localparam int IB = tkips_pkg::ID_BITS;
    localparam logic [CW-1:0] DIM_C  = CW'(MAX_DIM);
    localparam logic [FW-1:0] KEEP_C = FW'(MAX_KEEP);

    tkips_pkg::t_state r_state, n_state;

    logic [tkips_pkg::TOPK_BITS-1:0] r_top_k;
    logic [CW-1:0]           r_count, n_count, r_qlen, n_qlen;
    logic signed [SB-1:0]    r_acc, n_acc;
    logic                    r_mis, n_mis;
    logic signed [EB-1:0]    r_val, n_val;
    logic [IB-1:0]           r_id, n_id;
    logic                    r_last, n_last;
    logic                    r_empty, n_empty;
    logic signed [PB-1:0]    r_prod, n_prod;
    logic signed [SB-1:0]    r_new_score, n_new_score;
    logic [FW-1:0]           r_fill, n_fill;
    logic signed [SB-1:0]    r_best_score [MAX_KEEP];
    logic signed [SB-1:0]    n_best_score [MAX_KEEP];
    logic [IB-1:0]           r_best_id [MAX_KEEP];
    logic [IB-1:0]           n_best_id [MAX_KEEP];
    logic                    r_out_valid, n_out_valid;
    tkips_pkg::t_out_word    r_out_word, n_out_word;

    logic                    accept, out_free, do_mac, res_bad;
    logic [KW-1:0]           keep_k;
    logic [MAX_KEEP-1:0]     gt;
    logic signed [SB:0]      sum;
    logic signed [SB-1:0]    sat;
    logic [EB-1:0]           ram_rdata;
    logic                    ram_we;

    assign o_in_ready  = (r_state == tkips_pkg::S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign keep_k      = (KW'(r_top_k) > KW'(MAX_KEEP)) ? KW'(MAX_KEEP) : KW'(r_top_k);
    assign do_mac      = (r_count < r_qlen) && (r_count < DIM_C);
    assign ram_we      = accept && (i_in_word.action == tkips_pkg::ACT_QUERY) && (r_count < DIM_C);
    assign res_bad     = r_mis || (r_count != r_qlen);
    assign sum         = {r_acc[SB-1], r_acc} + (SB+1)'(r_prod);
    assign sat         = (sum[SB] != sum[SB-1]) ? (sum[SB] ? tkips_pkg::SCORE_MIN
                                                           : tkips_pkg::SCORE_MAX)
                                                : sum[SB-1:0];

    always_comb begin
        for (int i = 0; i < MAX_KEEP; i++) begin
            gt[i] = (FW'(i) < r_fill) && (r_best_score[i] > r_new_score);
        end
    end

    tkips_ram #(.WIDTH(EB), .DEPTH(MAX_DIM)) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in_word.element_value),
        .i_raddr (r_count[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tkips_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_in_word.action)
                        tkips_pkg::ACT_CAND: begin
                            if (do_mac) begin
                                n_state = tkips_pkg::S_MUL;
                            end else if (i_in_word.last_element) begin
                                n_state = tkips_pkg::S_RES;
                            end
                        end
                        tkips_pkg::ACT_DRAIN: n_state = tkips_pkg::S_DRAIN;
                        default:              n_state = tkips_pkg::S_IDLE;
                    endcase
                end
            end
            tkips_pkg::S_MUL: n_state = tkips_pkg::S_ACC;
            tkips_pkg::S_ACC: n_state = r_last ? tkips_pkg::S_RES : tkips_pkg::S_IDLE;
            tkips_pkg::S_RES: begin
                if (out_free) begin
                    n_state = (!res_bad && keep_k != '0) ? tkips_pkg::S_EVICT
                                                         : tkips_pkg::S_IDLE;
                end
            end
            tkips_pkg::S_EVICT: begin
                if (KW'(r_fill) >= keep_k &&
                    (r_fill == '0 || r_new_score <= r_best_score[0])) begin
                    n_state = tkips_pkg::S_IDLE;
                end else begin
                    n_state = tkips_pkg::S_PUT;
                end
            end
            tkips_pkg::S_PUT: n_state = tkips_pkg::S_IDLE;
            tkips_pkg::S_DRAIN: begin
                if (out_free && (r_empty || r_fill <= FW'(1))) begin
                    n_state = tkips_pkg::S_IDLE;
                end
            end
            default: n_state = tkips_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count     = r_count;
        n_qlen      = r_qlen;
        n_acc       = r_acc;
        n_mis       = r_mis;
        n_val       = r_val;
        n_id        = r_id;
        n_last      = r_last;
        n_empty     = r_empty;
        n_prod      = r_prod;
        n_new_score = r_new_score;
        n_fill      = r_fill;
        n_best_score = r_best_score;
        n_best_id    = r_best_id;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        case (r_state)
            tkips_pkg::S_IDLE: begin
                if (accept) begin
                    n_val  = i_in_word.element_value;
                    n_id   = i_in_word.candidate_id;
                    n_last = i_in_word.last_element;
                    case (i_in_word.action)
                        tkips_pkg::ACT_QUERY: begin
                            if (i_in_word.last_element) begin
                                n_qlen  = (r_count < DIM_C) ? r_count + CW'(1) : r_count;
                                n_count = '0;
                                n_acc   = '0;
                                n_mis   = 1'b0;
                            end else if (r_count < DIM_C) begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        tkips_pkg::ACT_CAND: begin
                            if (!do_mac) begin
                                n_mis = 1'b1;
                            end
                            if (r_count < DIM_C) begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        tkips_pkg::ACT_DRAIN: n_empty = (r_fill == '0);
                        default: begin
                            n_qlen  = '0;
                            n_fill  = '0;
                            n_count = '0;
                            n_acc   = '0;
                            n_mis   = 1'b0;
                        end
                    endcase
                end
            end
            tkips_pkg::S_MUL: n_prod = r_val * $signed(ram_rdata);
            tkips_pkg::S_ACC: n_acc = sat;
            tkips_pkg::S_RES: begin
                if (out_free) begin
                    n_out_valid            = 1'b1;
                    n_out_word.kind        = res_bad ? tkips_pkg::KIND_DROPPED
                                                     : tkips_pkg::KIND_SCORED;
                    n_out_word.entry_id    = r_id;
                    n_out_word.entry_score = res_bad ? '0 : r_acc;
                    n_out_word.last_in_run = 1'b1;
                    n_new_score            = r_acc;
                    n_count                = '0;
                    n_acc                  = '0;
                    n_mis                  = 1'b0;
                end
            end
            tkips_pkg::S_EVICT: begin
                if (KW'(r_fill) >= keep_k && r_fill != '0 &&
                    r_new_score > r_best_score[0]) begin
                    for (int i = 0; i < MAX_KEEP - 1; i++) begin
                        n_best_score[i] = r_best_score[i+1];
                        n_best_id[i]    = r_best_id[i+1];
                    end
                    n_fill = r_fill - FW'(1);
                end
            end
            tkips_pkg::S_PUT: begin
                if (r_fill < KEEP_C) begin
                    for (int i = 0; i < MAX_KEEP; i++) begin
                        if (i > 0 && gt[(i > 0) ? i-1 : 0]) begin
                            n_best_score[i] = r_best_score[(i > 0) ? i-1 : 0];
                            n_best_id[i]    = r_best_id[(i > 0) ? i-1 : 0];
                        end else if (gt[i] || FW'(i) == r_fill) begin
                            n_best_score[i] = r_new_score;
                            n_best_id[i]    = r_id;
                        end
                    end
                    n_fill = r_fill + FW'(1);
                end
            end
            tkips_pkg::S_DRAIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_empty) begin
                        n_out_word.kind        = tkips_pkg::KIND_EMPTY;
                        n_out_word.entry_id    = '0;
                        n_out_word.entry_score = '0;
                        n_out_word.last_in_run = 1'b1;
                    end else begin
                        n_out_word.kind        = tkips_pkg::KIND_RANKED;
                        n_out_word.entry_id    = r_best_id[0];
                        n_out_word.entry_score = r_best_score[0];
                        n_out_word.last_in_run = (r_fill == FW'(1));
                        for (int i = 0; i < MAX_KEEP - 1; i++) begin
                            n_best_score[i] = r_best_score[i+1];
                            n_best_id[i]    = r_best_id[i+1];
                        end
                        n_fill = r_fill - FW'(1);
                    end
                end
            end
            default: n_out_valid = r_out_valid && !i_out_ready;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tkips_pkg::S_IDLE;
            r_top_k     <= tkips_pkg::TOPK_RESET;
            r_count     <= '0;
            r_qlen      <= '0;
            r_acc       <= '0;
            r_mis       <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_qlen      <= n_qlen;
            r_acc       <= n_acc;
            r_mis       <= n_mis;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_top_k <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val        <= n_val;
        r_id         <= n_id;
        r_last       <= n_last;
        r_empty      <= n_empty;
        r_prod       <= n_prod;
        r_new_score  <= n_new_score;
        r_best_score <= n_best_score;
        r_best_id    <= n_best_id;
        r_out_word   <= n_out_word;
    end
endmodule

// ----- rtl/tkips_ram.sv -----
// generic single-write, single-read ram with registered read data
module tkips_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- rtl/tkips_checker.sv -----
// port-level checker for the top-k inner product search block, with its bind
`include "top_k_inner_product_search_macros.svh"

module tkips_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input tkips_pkg::t_in_word  i_in_word,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input tkips_pkg::t_out_word o_out_word
);
    `TKIPS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "output word dropped while stalled")
    `TKIPS_ASSERT_NXT(a_cand_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_word.action == tkips_pkg::ACT_CAND && i_in_word.last_element, !o_in_ready, "ready after last candidate word")
    `TKIPS_ASSERT_IMP(a_empty_word, i_clk, i_rst_n, o_out_valid && o_out_word.kind == tkips_pkg::KIND_EMPTY, o_out_word.last_in_run && o_out_word.entry_id == '0 && o_out_word.entry_score == '0, "bad store-empty word")
    `TKIPS_ASSERT_IMP(a_drop_word, i_clk, i_rst_n, o_out_valid && o_out_word.kind == tkips_pkg::KIND_DROPPED, o_out_word.last_in_run && o_out_word.entry_score == '0, "bad dropped word")
endmodule

bind top_k_inner_product_search tkips_checker u_tkips_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
